// ===== design/square_free_kernel_pair_count_unit_defines.svh =====
// Assertion macros shared by the square-free kernel pair count unit.
`ifndef SQUARE_FREE_KERNEL_PAIR_COUNT_UNIT_DEFINES_SVH
`define SQUARE_FREE_KERNEL_PAIR_COUNT_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled in reset.
`define SFKPC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and disabled in reset.
`define SFKPC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sfkpc_pkg.sv =====
// Types, constants and microcode table of the square-free kernel pair count unit.
`timescale 1ns / 1ps
`default_nettype none
package sfkpc_pkg;

  localparam int VALUE_BITS = 20;
  localparam int COUNT_BITS = 20;
  localparam int PAIR_BITS  = 40;
  localparam int HIST_DEPTH = 1 << VALUE_BITS;
  localparam int I_BITS     = VALUE_BITS / 2 + 1;
  localparam int SQ_BITS    = VALUE_BITS + 1;
  localparam int CNT_BITS   = $clog2(VALUE_BITS + 1);
  localparam int PC_BITS    = 4;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_DSTART,
    OP_DSTEP,
    OP_COMMIT,
    OP_NEXTI,
    OP_LOOKUP,
    OP_UPDATE
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_CLR_BUSY,
    C_NO_IN,
    C_V_LT2,
    C_SQ_GT_V,
    C_DIV_BUSY,
    C_REM_NZ,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t                op;
    cond_t              cond;
    logic [PC_BITS-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic clr_busy;
    logic no_in;
    logic v_lt2;
    logic sq_gt_v;
    logic div_busy;
    logic rem_nz;
    logic out_busy;
  } status_t;

  localparam logic [PC_BITS-1:0] STEP_CLEAR  = 4'd0;
  localparam logic [PC_BITS-1:0] STEP_WAIT   = 4'd1;
  localparam logic [PC_BITS-1:0] STEP_SMALL  = 4'd2;
  localparam logic [PC_BITS-1:0] STEP_TEST   = 4'd3;
  localparam logic [PC_BITS-1:0] STEP_DSTART = 4'd4;
  localparam logic [PC_BITS-1:0] STEP_DSTEP  = 4'd5;
  localparam logic [PC_BITS-1:0] STEP_DCHECK = 4'd6;
  localparam logic [PC_BITS-1:0] STEP_COMMIT = 4'd7;
  localparam logic [PC_BITS-1:0] STEP_NEXTI  = 4'd8;
  localparam logic [PC_BITS-1:0] STEP_LOOKUP = 4'd9;
  localparam logic [PC_BITS-1:0] STEP_UPDATE = 4'd10;
  localparam logic [PC_BITS-1:0] STEP_RETURN = 4'd11;
  localparam logic [PC_BITS-1:0] STEP_LAST   = STEP_RETURN;

  function automatic ucode_t ucode_rom(input logic [PC_BITS-1:0] pc);
    ucode_t w;
    unique case (pc)
      STEP_CLEAR:  w = '{op: OP_CLEAR,  cond: C_CLR_BUSY, target: STEP_CLEAR};
      STEP_WAIT:   w = '{op: OP_LOAD,   cond: C_NO_IN,    target: STEP_WAIT};
      STEP_SMALL:  w = '{op: OP_NONE,   cond: C_V_LT2,    target: STEP_LOOKUP};
      STEP_TEST:   w = '{op: OP_NONE,   cond: C_SQ_GT_V,  target: STEP_LOOKUP};
      STEP_DSTART: w = '{op: OP_DSTART, cond: C_NEVER,    target: STEP_WAIT};
      STEP_DSTEP:  w = '{op: OP_DSTEP,  cond: C_DIV_BUSY, target: STEP_DSTEP};
      STEP_DCHECK: w = '{op: OP_NONE,   cond: C_REM_NZ,   target: STEP_NEXTI};
      STEP_COMMIT: w = '{op: OP_COMMIT, cond: C_ALWAYS,   target: STEP_TEST};
      STEP_NEXTI:  w = '{op: OP_NEXTI,  cond: C_ALWAYS,   target: STEP_TEST};
      STEP_LOOKUP: w = '{op: OP_LOOKUP, cond: C_NEVER,    target: STEP_WAIT};
      STEP_UPDATE: w = '{op: OP_UPDATE, cond: C_OUT_BUSY, target: STEP_UPDATE};
      STEP_RETURN: w = '{op: OP_NONE,   cond: C_ALWAYS,   target: STEP_WAIT};
      default:     w = '{op: OP_NONE,   cond: C_ALWAYS,   target: STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== design/sfkpc_divider.sv =====
// One-bit-per-cycle restoring divider for the kernel reduction.
`timescale 1ns / 1ps
`default_nettype none
`include "square_free_kernel_pair_count_unit_defines.svh"
module sfkpc_divider (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic                             step,
  input  wire logic [sfkpc_pkg::VALUE_BITS-1:0] dividend,
  input  wire logic [sfkpc_pkg::SQ_BITS-1:0]    divisor,
  output logic      [sfkpc_pkg::VALUE_BITS-1:0] quotient,
  output logic                                  busy,
  output logic                                  rem_nonzero
);
  import sfkpc_pkg::*;

  logic [VALUE_BITS-1:0] quo;
  logic [VALUE_BITS-1:0] quo_next;
  logic [VALUE_BITS-1:0] rem;
  logic [VALUE_BITS-1:0] rem_next;
  logic [CNT_BITS-1:0]   cnt;
  logic [SQ_BITS-1:0]    trial;
  logic [SQ_BITS-1:0]    diff;
  logic                  ge;

  always_comb begin
    trial    = {rem, quo[VALUE_BITS-1]};
    ge       = (trial >= divisor);
    diff     = trial - divisor;
    rem_next = ge ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
    quo_next = {quo[VALUE_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_BITS'(VALUE_BITS);
    end else if (step && (cnt != '0)) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (step) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quotient    = quo;
  assign busy        = (cnt != CNT_BITS'(1));
  assign rem_nonzero = (rem != '0);

  `SFKPC_ASSERT_IMP(a_rem_below_divisor, step, {1'b0, rem} < divisor,
                    "divider remainder reached the divisor")
  `SFKPC_ASSERT_NXT(a_start_loads_count, start, cnt == CNT_BITS'(VALUE_BITS),
                    "divider did not load its step count")
endmodule
`default_nettype wire

// ===== design/sfkpc_sequencer.sv =====
// Microcode sequencer: step counter, control table and conditional jumps.
`timescale 1ns / 1ps
`default_nettype none
`include "square_free_kernel_pair_count_unit_defines.svh"
module sfkpc_sequencer (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sfkpc_pkg::status_t status,
  output sfkpc_pkg::op_t          op
);
  import sfkpc_pkg::*;

  logic [PC_BITS-1:0] pc;
  logic [PC_BITS-1:0] pc_next;
  ucode_t             cw;
  logic               take;

  always_comb begin
    cw = ucode_rom(pc);
    unique case (cw.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_CLR_BUSY: take = status.clr_busy;
      C_NO_IN:    take = status.no_in;
      C_V_LT2:    take = status.v_lt2;
      C_SQ_GT_V:  take = status.sq_gt_v;
      C_DIV_BUSY: take = status.div_busy;
      C_REM_NZ:   take = status.rem_nz;
      C_OUT_BUSY: take = status.out_busy;
      default:    take = 1'b1;
    endcase
    pc_next = take ? cw.target : pc + 1'b1;
    op      = cw.op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_CLEAR;
    end else begin
      pc <= pc_next;
    end
  end

  `SFKPC_ASSERT_IMP(a_pc_in_program, 1'b1, pc <= STEP_LAST,
                    "step counter left the program")
endmodule
`default_nettype wire

// ===== design/sfkpc_datapath.sv =====
// Datapath: value and divisor registers, kernel histogram, pair total, result register.
`timescale 1ns / 1ps
`default_nettype none
`include "square_free_kernel_pair_count_unit_defines.svh"
module sfkpc_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire sfkpc_pkg::op_t                   op,
  output sfkpc_pkg::status_t                    status,
  input  wire logic                             in_valid,
  input  wire logic [sfkpc_pkg::VALUE_BITS-1:0] value,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic      [sfkpc_pkg::VALUE_BITS-1:0] kernel,
  output logic      [sfkpc_pkg::PAIR_BITS-1:0]  pair_total
);
  import sfkpc_pkg::*;

  logic [VALUE_BITS-1:0] v;
  logic [I_BITS-1:0]     i;
  logic [SQ_BITS-1:0]    sq;
  logic [VALUE_BITS-1:0] clr_addr;
  logic [PAIR_BITS-1:0]  acc;
  logic [PAIR_BITS-1:0]  acc_next;
  logic [PAIR_BITS:0]    sum;
  logic [COUNT_BITS-1:0] hist_mem [HIST_DEPTH];
  logic [COUNT_BITS-1:0] count;
  logic                  hist_we;
  logic [VALUE_BITS-1:0] hist_wa;
  logic [COUNT_BITS-1:0] hist_wd;
  logic [VALUE_BITS-1:0] quotient;
  logic                  div_busy;
  logic                  rem_nz;
  logic                  out_busy;
  logic                  update;

  sfkpc_divider u_divider (
    .clk        (clk),
    .rst        (rst),
    .start      (op == OP_DSTART),
    .step       (op == OP_DSTEP),
    .dividend   (v),
    .divisor    (sq),
    .quotient   (quotient),
    .busy       (div_busy),
    .rem_nonzero(rem_nz)
  );

  always_comb begin
    out_busy = out_valid && out_stall;
    update   = (op == OP_UPDATE) && !out_busy;
    sum      = {1'b0, acc} + (PAIR_BITS + 1)'(count);
    acc_next = sum[PAIR_BITS] ? '1 : sum[PAIR_BITS-1:0];
    hist_we  = (op == OP_CLEAR) || (update && (count != '1));
    hist_wa  = (op == OP_CLEAR) ? clr_addr : v;
    hist_wd  = (op == OP_CLEAR) ? '0 : count + 1'b1;

    status.clr_busy = (clr_addr != '1);
    status.no_in    = !in_valid;
    status.v_lt2    = (v < VALUE_BITS'(2));
    status.sq_gt_v  = (sq > {1'b0, v});
    status.div_busy = div_busy;
    status.rem_nz   = rem_nz;
    status.out_busy = out_busy;
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    if (op == OP_LOOKUP) begin
      count <= hist_mem[v];
    end
  end

  always_ff @(posedge clk) begin
    if ((op == OP_LOAD) && in_valid) begin
      v  <= value;
      i  <= I_BITS'(2);
      sq <= SQ_BITS'(4);
    end else if (op == OP_COMMIT) begin
      v <= quotient;
    end else if (op == OP_NEXTI) begin
      i  <= i + 1'b1;
      sq <= sq + SQ_BITS'({i, 1'b1});
    end
    if (update) begin
      kernel     <= v;
      pair_total <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (op == OP_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (update) begin
        acc       <= acc_next;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `SFKPC_ASSERT_NXT(a_commit_shrinks, op == OP_COMMIT, v < $past(v),
                    "removing a square factor did not shrink the value")
  `SFKPC_ASSERT_NXT(a_total_monotonic, 1'b1, acc >= $past(acc),
                    "pair total decreased")
  `SFKPC_ASSERT_IMP(a_update_drives_total, update, acc_next >= acc,
                    "pair total update would wrap")
endmodule
`default_nettype wire

// ===== design/square_free_kernel_pair_count_unit.sv =====
// Top level of the square-free kernel pair count unit.
// Usage: each request on the input channel (in_valid, in_stall, value) carries one
// unsigned value. The unit reduces it to its square-free kernel by trial division
// with every square i*i, counts kernels in a 2^20-entry histogram, and returns the
// kernel with the running pair total (saturating at 2^40 - 1) on the output channel
// (out_valid, out_stall, kernel, pair_total).
// One request is worked on at a time. Every trial division runs on the single
// one-bit-per-cycle restoring divider shared by all candidate squares, and inputs
// of 0 or 1 skip trial division. After a result is written the unit passes through
// a return step before the next request is accepted.
// After reset the histogram is swept to zero, one entry a cycle, across all 1,048,576
// entries; in_stall stays high during that sweep.
// A finished result sits in the output register; the next request is accepted
// while it waits, and only the write of the following result waits for the
// receiver to release out_stall.
`timescale 1ns / 1ps
`default_nettype none
module square_free_kernel_pair_count_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [sfkpc_pkg::VALUE_BITS-1:0] value,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic      [sfkpc_pkg::VALUE_BITS-1:0] kernel,
  output logic      [sfkpc_pkg::PAIR_BITS-1:0]  pair_total
);
  import sfkpc_pkg::*;

  op_t     op;
  status_t status;

  sfkpc_sequencer u_sequencer (
    .clk   (clk),
    .rst   (rst),
    .status(status),
    .op    (op)
  );

  sfkpc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .status    (status),
    .in_valid  (in_valid),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kernel    (kernel),
    .pair_total(pair_total)
  );

  assign in_stall = (op != OP_LOAD);
endmodule
`default_nettype wire
